// ----- sv/tob_pkg.sv -----
// Shared types, constants and a helper function for the tick OHLC bar aggregator.
package tob_pkg;

    localparam int unsigned PRICE_W  = 32;
    localparam int unsigned WIDE_W   = 33;
    localparam int unsigned BARSEC_W = 20;
    localparam logic [BARSEC_W-1:0] BARSEC_RESET = 20'd60;
    localparam logic [WIDE_W-1:0]   TIME_MAX     = 33'h1_FFFF_FFFF;
    // Days from 0000-03-01 (shifted by one 400-year era) to 1970-01-01
    localparam logic [24:0] EPOCH_OFFSET = 25'd865565;
    // Reciprocal of 100 scaled by 2^19, exact for the year range in use
    localparam logic [12:0] RECIP100 = 13'd5243;
    localparam int unsigned RECIP_SH = 19;
    localparam logic signed [42:0] SEC_PER_DAY = 43'sd86400;

    typedef enum logic [2:0] {
        F_IDLE,
        F_CALC1,
        F_CALC2,
        F_MUL,
        F_SUM,
        F_DIV,
        F_PUSH
    } tob_front_state_t;

    // One classified item handed from the front to the back
    typedef struct packed {
        logic              flush;
        logic [WIDE_W-1:0] bucket;
        logic [WIDE_W-1:0] mid;
    } tob_item_t;

    // Day of the March-based year at which the month starts
    function automatic logic [8:0] tob_month_doy(input logic [3:0] m);
        logic [8:0] r;
        begin
            unique case (m)
                4'd1:    r = 9'd306;
                4'd2:    r = 9'd337;
                4'd3:    r = 9'd0;
                4'd4:    r = 9'd31;
                4'd5:    r = 9'd61;
                4'd6:    r = 9'd92;
                4'd7:    r = 9'd122;
                4'd8:    r = 9'd153;
                4'd9:    r = 9'd184;
                4'd10:   r = 9'd214;
                4'd11:   r = 9'd245;
                4'd12:   r = 9'd275;
                default: r = 9'd0;
            endcase
            return r;
        end
    endfunction

endpackage

// ----- sv/tob_fifo.sv -----
// Two-entry queue between the front and back parts.
module tob_fifo
    import tob_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  tob_item_t push_item,
    output logic      full,
    input  logic      pop,
    output logic      head_valid,
    output tob_item_t head_item
);

    tob_item_t  mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write the entry on push
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_item  = mem[rd_ptr_reg];

endmodule

// ----- sv/tob_front.sv -----
// Front part: accepts ticks, builds Unix time and mid, finds the bar start.
module tob_front
    import tob_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                kind,
    input  logic [11:0]         year,
    input  logic [3:0]          month,
    input  logic [4:0]          day,
    input  logic [4:0]          hour,
    input  logic [5:0]          minute,
    input  logic [5:0]          second,
    input  logic [PRICE_W-1:0]  bid_price,
    input  logic [PRICE_W-1:0]  ask_price,
    input  logic [BARSEC_W-1:0] bar_seconds,
    output logic                push,
    output tob_item_t           push_item,
    input  logic                fifo_full
);

    tob_front_state_t state_reg, state_next;

    logic               flush_reg;
    logic [WIDE_W-1:0]  mid_reg;
    logic [13:0]        y_reg;
    logic [3:0]         m_reg;
    logic [4:0]         d_reg;
    logic [4:0]         hh_reg;
    logic [5:0]         mi_reg;
    logic [5:0]         ss_reg;
    logic [12:0]        yy_reg;
    logic [25:0]        c100_reg;
    logic [23:0]        c400_reg;
    logic [21:0]        d365_reg;
    logic [8:0]         doy_reg;
    logic [16:0]        tod_reg;
    logic signed [24:0] days_reg;
    logic signed [42:0] prod_reg;
    logic [WIDE_W-1:0]  t_reg;
    logic [WIDE_W-1:0]  tsh_reg;
    logic [BARSEC_W-1:0] rem_reg;
    logic [5:0]         cnt_reg;

    logic [BARSEC_W-1:0] w_eff;
    logic               accept;
    logic               drop;
    logic [13:0]        y_in;
    logic [3:0]         m_in;
    logic [13:0]        yy_full;
    logic [12:0]        yy;
    logic [24:0]        days_sum;
    logic signed [42:0] t_full;
    logic [WIDE_W-1:0]  t_sat;
    logic [BARSEC_W:0]  rem_sh;
    logic [BARSEC_W-1:0] rem_step;

    assign w_eff    = (bar_seconds == '0) ? BARSEC_W'(1) : bar_seconds;
    assign in_stall = (state_reg != F_IDLE);
    assign accept   = in_valid && !in_stall;
    assign drop     = !kind && ((bid_price == '0) || (ask_price == '0));

    // Fold out-of-range months into the neighboring year
    always_comb
    begin
        if (month == 4'd0)
        begin
            y_in = {2'b00, year} - 14'd1;
            m_in = 4'd12;
        end
        else if (month > 4'd12)
        begin
            y_in = {2'b00, year} + 14'd1;
            m_in = month - 4'd12;
        end
        else
        begin
            y_in = {2'b00, year};
            m_in = month;
        end
    end

    // Shifted year, March-based: always positive for any input pattern
    assign yy_full = y_reg + 14'd400 - {13'd0, (m_reg <= 4'd2)};
    assign yy      = yy_full[12:0];

    assign days_sum = 25'(d365_reg) + 25'(yy_reg >> 2)
                    - 25'(c100_reg >> RECIP_SH) + 25'(c400_reg >> RECIP_SH)
                    + 25'(doy_reg) + 25'(d_reg) - 25'd1 - EPOCH_OFFSET;

    assign t_full = prod_reg + $signed({26'd0, tod_reg});

    // Saturate the time to the 33-bit range
    always_comb
    begin
        if (t_full < 0)
        begin
            t_sat = '0;
        end
        else if (t_full > $signed({10'd0, TIME_MAX}))
        begin
            t_sat = TIME_MAX;
        end
        else
        begin
            t_sat = t_full[WIDE_W-1:0];
        end
    end

    // One restoring division step on the remainder
    always_comb
    begin
        rem_sh = {rem_reg, tsh_reg[WIDE_W-1]};
        if (rem_sh >= {1'b0, w_eff})
        begin
            rem_sh = rem_sh - {1'b0, w_eff};
        end
        rem_step = rem_sh[BARSEC_W-1:0];
    end

    // Next state and push
    always_comb
    begin
        state_next = state_reg;
        push       = 1'b0;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept && !drop)
                begin
                    state_next = kind ? F_PUSH : F_CALC1;
                end
            end
            F_CALC1: state_next = F_CALC2;
            F_CALC2: state_next = F_MUL;
            F_MUL:   state_next = F_SUM;
            F_SUM:   state_next = F_DIV;
            F_DIV:
            begin
                if (cnt_reg == 6'd1)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!fifo_full)
                begin
                    push       = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            flush_reg <= kind;
            mid_reg   <= {1'b0, bid_price} + {1'b0, ask_price};
            y_reg     <= y_in;
            m_reg     <= m_in;
            d_reg     <= day;
            hh_reg    <= hour;
            mi_reg    <= minute;
            ss_reg    <= second;
        end
        if (state_reg == F_CALC1)
        begin
            yy_reg   <= yy;
            c100_reg <= 26'(yy) * 26'(RECIP100);
            c400_reg <= 24'(yy >> 2) * 24'(RECIP100);
            d365_reg <= 22'(yy) * 22'd365;
            doy_reg  <= tob_month_doy(m_reg);
            tod_reg  <= 17'(hh_reg) * 17'd3600 + 17'(mi_reg) * 17'd60 + 17'(ss_reg);
        end
        if (state_reg == F_CALC2)
        begin
            days_reg <= $signed(days_sum);
        end
        if (state_reg == F_MUL)
        begin
            prod_reg <= $signed({{18{days_reg[24]}}, days_reg}) * SEC_PER_DAY;
        end
        if (state_reg == F_SUM)
        begin
            t_reg   <= t_sat;
            tsh_reg <= t_sat;
            rem_reg <= '0;
            cnt_reg <= 6'(WIDE_W);
        end
        if (state_reg == F_DIV)
        begin
            rem_reg <= rem_step;
            tsh_reg <= {tsh_reg[WIDE_W-2:0], 1'b0};
            cnt_reg <= cnt_reg - 6'd1;
        end
    end

    assign push_item.flush  = flush_reg;
    assign push_item.bucket = t_reg - {13'd0, rem_reg};
    assign push_item.mid    = mid_reg;

endmodule

// ----- sv/tob_back.sv -----
// Back part: keeps the open bar and emits finished bars through an output register.
module tob_back
    import tob_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  tob_item_t         head_item,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [WIDE_W-1:0] bar_start,
    output logic [WIDE_W-1:0] open_mid,
    output logic [WIDE_W-1:0] high_mid,
    output logic [WIDE_W-1:0] low_mid,
    output logic [WIDE_W-1:0] close_mid
);

    logic              open_reg;
    logic [WIDE_W-1:0] cur_reg, opn_reg, hi_reg, lo_reg, cls_reg;
    logic              out_valid_reg;
    logic [WIDE_W-1:0] o_start_reg, o_open_reg, o_high_reg, o_low_reg, o_close_reg;

    logic emit_need;
    logic out_free;

    assign emit_need = open_reg &&
                       (head_item.flush || (head_item.bucket != cur_reg));
    assign out_free  = !out_valid_reg || !out_stall;
    assign pop       = head_valid && (!emit_need || out_free);

    // Update the open bar
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
            cur_reg  <= '0;
            opn_reg  <= '0;
            hi_reg   <= '0;
            lo_reg   <= '0;
            cls_reg  <= '0;
        end
        else if (pop)
        begin
            if (head_item.flush)
            begin
                open_reg <= 1'b0;
                cur_reg  <= '0;
                opn_reg  <= '0;
                hi_reg   <= '0;
                lo_reg   <= '0;
                cls_reg  <= '0;
            end
            else if (!open_reg || (head_item.bucket != cur_reg))
            begin
                open_reg <= 1'b1;
                cur_reg  <= head_item.bucket;
                opn_reg  <= head_item.mid;
                hi_reg   <= head_item.mid;
                lo_reg   <= head_item.mid;
                cls_reg  <= head_item.mid;
            end
            else
            begin
                if (head_item.mid > hi_reg)
                begin
                    hi_reg <= head_item.mid;
                end
                if (head_item.mid < lo_reg)
                begin
                    lo_reg <= head_item.mid;
                end
                cls_reg <= head_item.mid;
            end
        end
    end

    // Hold the finished bar until its transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop && emit_need)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && emit_need)
        begin
            o_start_reg <= cur_reg;
            o_open_reg  <= opn_reg;
            o_high_reg  <= hi_reg;
            o_low_reg   <= lo_reg;
            o_close_reg <= cls_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign bar_start = o_start_reg;
    assign open_mid  = o_open_reg;
    assign high_mid  = o_high_reg;
    assign low_mid   = o_low_reg;
    assign close_mid = o_close_reg;

    a_pop_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop without a queued item");

    a_flush_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head_item.flush) |=> !open_reg)
        else $error("bar still open after flush");

    a_high_ge_low: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg |-> (hi_reg >= lo_reg))
        else $error("bar high below low");

    a_emit_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && emit_need) |=> out_valid_reg)
        else $error("emitted bar not presented");

endmodule

// ----- sv/tick_ohlc_bar_aggregator.sv -----
// A tick holds the front from acceptance through 4 time steps and 33 divide steps to the push.
// The push waits while the queue is full; the front takes no new tick while busy (in_stall).
// A flush goes from acceptance straight to the push; dropped zero-price ticks leave the front idle.
// A bar closed by an item is loaded into the output register when that item is popped from the queue.
// Reset (rst_n low, asynchronous) closes any open bar and sets bar_seconds to 60.
module tick_ohlc_bar_aggregator
    import tob_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                kind,
    input  logic [11:0]         year,
    input  logic [3:0]          month,
    input  logic [4:0]          day,
    input  logic [4:0]          hour,
    input  logic [5:0]          minute,
    input  logic [5:0]          second,
    input  logic [PRICE_W-1:0]  bid_price,
    input  logic [PRICE_W-1:0]  ask_price,
    input  logic                bar_seconds_we,
    input  logic [BARSEC_W-1:0] bar_seconds_wdata,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [WIDE_W-1:0]   bar_start,
    output logic [WIDE_W-1:0]   open_mid,
    output logic [WIDE_W-1:0]   high_mid,
    output logic [WIDE_W-1:0]   low_mid,
    output logic [WIDE_W-1:0]   close_mid
);

    logic [BARSEC_W-1:0] bar_seconds_reg;
    logic                push;
    tob_item_t           push_item;
    logic                fifo_full;
    logic                pop;
    logic                head_valid;
    tob_item_t           head_item;

    // Hold the bar length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bar_seconds_reg <= BARSEC_RESET;
        end
        else if (bar_seconds_we)
        begin
            bar_seconds_reg <= bar_seconds_wdata;
        end
    end

    tob_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .year        (year),
        .month       (month),
        .day         (day),
        .hour        (hour),
        .minute      (minute),
        .second      (second),
        .bid_price   (bid_price),
        .ask_price   (ask_price),
        .bar_seconds (bar_seconds_reg),
        .push        (push),
        .push_item   (push_item),
        .fifo_full   (fifo_full)
    );

    tob_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (fifo_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    tob_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .bar_start  (bar_start),
        .open_mid   (open_mid),
        .high_mid   (high_mid),
        .low_mid    (low_mid),
        .close_mid  (close_mid)
    );

endmodule

// ----- bench/tick_ohlc_bar_aggregator_test.sv -----
// Testbench for the tick OHLC bar aggregator: random and directed ticks checked against a predictor.
module tick_ohlc_bar_aggregator_test;
    import tob_pkg::*;

    typedef struct {
        logic        kind;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [31:0] bid;
        logic [31:0] ask;
    } tick_t;

    typedef struct {
        logic [WIDE_W-1:0] start;
        logic [WIDE_W-1:0] open;
        logic [WIDE_W-1:0] high;
        logic [WIDE_W-1:0] low;
        logic [WIDE_W-1:0] close;
    } bar_t;

    // Bar predictor plus queue of finished bars still owed by the block
    class bar_scoreboard;
        bar_t              owed_bars[$];
        int                errors;
        logic [19:0]       bar_len;
        bit                bar_open;
        logic [WIDE_W-1:0] cur_start, cur_open, cur_high, cur_low, cur_close;

        function new();
            errors = 0;
            bar_len = BARSEC_RESET;
            clear_bar();
        endfunction

        function void clear_bar();
            bar_open = 0;
            cur_start = '0;
            cur_open = '0;
            cur_high = '0;
            cur_low = '0;
            cur_close = '0;
        endfunction

        // Days from 1970-01-01 to the first day of month m of year y
        function longint days_from_epoch(longint y, longint m);
            longint yy, era, yoe, mp, doy, doe;
            yy = y + 400 - ((m <= 2) ? 1 : 0);
            era = yy / 400;
            yoe = yy - era * 400;
            mp = (m > 2) ? (m - 3) : (m + 9);
            doy = (153 * mp + 2) / 5;
            doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
            return era * 146097 + doe - 719468 - 146097;
        endfunction

        function logic [WIDE_W-1:0] epoch_seconds(tick_t x);
            longint y, m, t;
            y = x.year;
            m = x.month;
            if (m == 0)
            begin
                m = 12;
                y = y - 1;
            end
            else if (m > 12)
            begin
                m = m - 12;
                y = y + 1;
            end
            t = (days_from_epoch(y, m) + x.day - 1) * 86400 + x.hour * 3600
                + x.minute * 60 + x.second;
            if (t < 0)
                return '0;
            if (t > longint'(TIME_MAX))
                return TIME_MAX;
            return t[WIDE_W-1:0];
        endfunction

        function void push_bar();
            bar_t b;
            b.start = cur_start;
            b.open = cur_open;
            b.high = cur_high;
            b.low = cur_low;
            b.close = cur_close;
            owed_bars.push_back(b);
        endfunction

        // Advance the predicted bar state by one accepted input transfer
        function void note_input(tick_t x);
            logic [WIDE_W-1:0] mid, t, bucket;
            longint unsigned w;
            if (x.kind)
            begin
                if (bar_open)
                    push_bar();
                clear_bar();
                return;
            end
            if (x.bid == 0 || x.ask == 0)
                return;
            mid = {1'b0, x.bid} + {1'b0, x.ask};
            t = epoch_seconds(x);
            w = (bar_len == 0) ? 1 : bar_len;
            bucket = (longint'(t) / w) * w;
            if (!bar_open || bucket != cur_start)
            begin
                if (bar_open)
                    push_bar();
                bar_open = 1;
                cur_start = bucket;
                cur_open = mid;
                cur_high = mid;
                cur_low = mid;
                cur_close = mid;
            end
            else
            begin
                if (mid > cur_high)
                    cur_high = mid;
                if (mid < cur_low)
                    cur_low = mid;
                cur_close = mid;
            end
        endfunction

        // Compare one output transfer with the oldest owed bar
        function void check_bar(bar_t got);
            bar_t exp_bar;
            if (owed_bars.size() == 0)
            begin
                $error("unexpected bar start=%0d", got.start);
                errors++;
                return;
            end
            exp_bar = owed_bars.pop_front();
            if (got.start !== exp_bar.start)
            begin
                $error("bar_start expected %0d got %0d", exp_bar.start, got.start);
                errors++;
            end
            if (got.open !== exp_bar.open)
            begin
                $error("open_mid expected %0d got %0d", exp_bar.open, got.open);
                errors++;
            end
            if (got.high !== exp_bar.high)
            begin
                $error("high_mid expected %0d got %0d", exp_bar.high, got.high);
                errors++;
            end
            if (got.low !== exp_bar.low)
            begin
                $error("low_mid expected %0d got %0d", exp_bar.low, got.low);
                errors++;
            end
            if (got.close !== exp_bar.close)
            begin
                $error("close_mid expected %0d got %0d", exp_bar.close, got.close);
                errors++;
            end
        endfunction
    endclass

    localparam int STUCK_LIMIT = 20000;
    localparam int HOLD_CYCLES = 1500;

    logic              clk = 0;
    logic              rst_n = 0;
    logic              in_valid = 0;
    logic              in_stall;
    logic              kind = 0;
    logic [11:0]       year = 0;
    logic [3:0]        month = 0;
    logic [4:0]        day = 0;
    logic [4:0]        hour = 0;
    logic [5:0]        minute = 0;
    logic [5:0]        second = 0;
    logic [31:0]       bid_price = 0;
    logic [31:0]       ask_price = 0;
    logic              bar_seconds_we = 0;
    logic [19:0]       bar_seconds_wdata = 0;
    logic              out_valid;
    logic              out_stall = 0;
    logic [WIDE_W-1:0] bar_start, open_mid, high_mid, low_mid, close_mid;

    bar_scoreboard sb = new();
    bit            quiet = 0;
    bit            hold_req = 0;
    int            stuck = 0;

    tick_ohlc_bar_aggregator dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .kind(kind), .year(year), .month(month), .day(day), .hour(hour),
        .minute(minute), .second(second), .bid_price(bid_price), .ask_price(ask_price),
        .bar_seconds_we(bar_seconds_we), .bar_seconds_wdata(bar_seconds_wdata),
        .out_valid(out_valid), .out_stall(out_stall),
        .bar_start(bar_start), .open_mid(open_mid), .high_mid(high_mid),
        .low_mid(low_mid), .close_mid(close_mid)
    );

    always #5 clk = ~clk;

    // Monitor both channels and the stall watchdog
    always @(posedge clk)
    begin
        bar_t got;
        if (in_valid && !in_stall)
            sb.note_input('{kind, year, month, day, hour, minute, second, bid_price,
                            ask_price});
        if (out_valid && !out_stall)
        begin
            got = '{bar_start, open_mid, high_mid, low_mid, close_mid};
            sb.check_bar(got);
        end
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            stuck = 0;
        else
            stuck++;
        if (stuck >= STUCK_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver: random stall bursts, one long hold-off, none at the end
    initial
    begin
        bit held;
        int n;
        held = 0;
        forever
        begin
            if (hold_req && !held)
            begin
                held = 1;
                out_stall <= 1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                n = $urandom_range(1, 9);
                out_stall <= 1;
                repeat (n) @(posedge clk);
            end
            else
            begin
                n = $urandom_range(1, 20);
                out_stall <= 0;
                repeat (n) @(posedge clk);
            end
        end
    end

    function automatic tick_t make_tick(int k, int y, int mo, int d, int h, int mi, int s,
                                        logic [31:0] b, logic [31:0] a);
        tick_t x;
        x.kind = 1'(k);
        x.year = 12'(y);
        x.month = 4'(mo);
        x.day = 5'(d);
        x.hour = 5'(h);
        x.minute = 6'(mi);
        x.second = 6'(s);
        x.bid = b;
        x.ask = a;
        return x;
    endfunction

    function automatic logic [31:0] rand_price();
        case ($urandom_range(0, 7))
            0: return 32'hFFFF_FFFF;
            1: return 32'd1;
            2: return $urandom();
            default: return 32'd1_000_000 + $urandom_range(0, 5000);
        endcase
    endfunction

    function automatic tick_t noise_tick();
        tick_t x;
        x.kind = ($urandom_range(0, 9) == 0);
        x.year = 12'($urandom());
        x.month = 4'($urandom());
        x.day = 5'($urandom());
        x.hour = 5'($urandom());
        x.minute = 6'($urandom());
        x.second = 6'($urandom());
        x.bid = ($urandom_range(0, 5) == 0) ? 32'd0 : $urandom();
        x.ask = ($urandom_range(0, 5) == 0) ? 32'd0 : $urandom();
        return x;
    endfunction

    // Offer one item and hold it until the transfer happens
    task automatic send_item(tick_t x);
        int n;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(1, 9);
            in_valid <= 0;
            repeat (n) @(posedge clk);
        end
        in_valid <= 1;
        kind <= x.kind;
        year <= x.year;
        month <= x.month;
        day <= x.day;
        hour <= x.hour;
        minute <= x.minute;
        second <= x.second;
        bid_price <= x.bid;
        ask_price <= x.ask;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Drain all owed bars, then let the front settle
    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (sb.owed_bars.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_bar_len(logic [19:0] v);
        bar_seconds_we <= 1;
        bar_seconds_wdata <= v;
        @(posedge clk);
        bar_seconds_we <= 0;
        sb.bar_len = v;
    endtask

    // Sorted sessions with random content, mixed with noise and flushes
    task automatic random_phase(int count, int max_step);
        int sent, y, mo, d, secs, len;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                send_item(noise_tick());
                sent++;
            end
            else
            begin
                y = $urandom_range(1970, 2099);
                mo = $urandom_range(1, 12);
                d = $urandom_range(1, 28);
                secs = $urandom_range(0, 80000);
                len = $urandom_range(3, 25);
                repeat (len)
                begin
                    secs = secs + $urandom_range(0, max_step);
                    if (secs > 86399)
                        secs = 86399;
                    send_item(make_tick(0, y, mo, d, secs / 3600, (secs / 60) % 60,
                                        secs % 60, rand_price(), rand_price()));
                    sent++;
                end
                if ($urandom_range(0, 1) == 0)
                begin
                    send_item(make_tick(1, 0, 0, 0, 0, 0, 0, 0, 0));
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        tick_t dir[$];
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: flush on empty, price extremes, zero prices, odd dates
        dir.push_back(make_tick(1, 0, 0, 0, 0, 0, 0, 0, 0));
        dir.push_back(make_tick(0, 1970, 1, 1, 0, 0, 0, 1, 1));
        dir.push_back(make_tick(0, 1970, 1, 1, 0, 0, 30, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        dir.push_back(make_tick(0, 1970, 1, 1, 0, 0, 40, 5, 5));
        dir.push_back(make_tick(0, 1970, 1, 1, 0, 0, 59, 0, 7));
        dir.push_back(make_tick(0, 1970, 1, 1, 0, 0, 59, 7, 0));
        dir.push_back(make_tick(0, 1970, 1, 1, 0, 0, 59, 9, 9));
        dir.push_back(make_tick(1, 4095, 15, 31, 31, 63, 63, 32'hFFFF_FFFF, 1));
        dir.push_back(make_tick(1, 0, 0, 0, 0, 0, 0, 0, 0));
        dir.push_back(make_tick(0, 2024, 0, 15, 12, 0, 0, 100, 200));
        dir.push_back(make_tick(0, 2024, 13, 15, 12, 0, 0, 100, 200));
        dir.push_back(make_tick(0, 2024, 15, 15, 12, 0, 0, 100, 200));
        dir.push_back(make_tick(0, 2023, 2, 0, 0, 0, 0, 100, 200));
        dir.push_back(make_tick(0, 2023, 2, 31, 0, 0, 0, 100, 200));
        dir.push_back(make_tick(0, 2024, 2, 29, 24, 0, 0, 100, 200));
        dir.push_back(make_tick(0, 2024, 3, 1, 31, 63, 63, 100, 200));
        dir.push_back(make_tick(0, 2010, 6, 1, 0, 0, 0, 100, 200));
        dir.push_back(make_tick(0, 1969, 12, 31, 23, 59, 59, 300, 300));
        dir.push_back(make_tick(0, 0, 0, 0, 0, 0, 0, 300, 301));
        dir.push_back(make_tick(0, 4095, 15, 31, 31, 63, 63, 1, 2));
        dir.push_back(make_tick(0, 2099, 12, 31, 23, 59, 59, 1, 2));
        dir.push_back(make_tick(1, 0, 0, 0, 0, 0, 0, 0, 0));
        foreach (dir[i])
            send_item(dir[i]);
        random_phase(100, 20);
        drain();

        // Shortest bars, with a long receiver hold-off to back up the block
        write_bar_len(20'd1);
        hold_req = 1;
        random_phase(120, 3);
        drain();

        write_bar_len(20'd0);
        random_phase(80, 3);
        drain();

        write_bar_len(20'hFFFFF);
        random_phase(100, 4000);
        drain();

        write_bar_len(20'd3600);
        random_phase(100, 600);
        drain();

        write_bar_len(20'($urandom_range(1, 20'hFFFFF)));
        random_phase(80, 5000);
        drain();

        // Final stretch runs without idling on either side
        write_bar_len(20'd60);
        quiet = 1;
        random_phase(100, 40);
        drain();

        if (sb.errors == 0 && sb.owed_bars.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
